// ===== design/spg_pkg.sv =====
// shared types and constants for the set partition generator
// no dependencies; imported by spg_label_store and set_partition_generator_core
package spg_pkg;

  localparam int unsigned MaxSetSize = 16;
  localparam int unsigned IdxW       = 4;   // position index, 0 .. MaxSetSize-1
  localparam int unsigned LblW       = 5;   // label, 1 .. MaxSetSize

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(MaxSetSize - 1);
  localparam logic [LblW-1:0] MaxSize  = LblW'(MaxSetSize);
  localparam logic [LblW-1:0] LblOne   = LblW'(1);
  localparam logic [LblW-1:0] LblZero  = LblW'(0);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [LblW-1:0] lbl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXH,
    ST_EMIT
  } spg_state_e;

  // write port of the label store
  typedef struct packed {
    logic en;
    idx_t addr;
    lbl_t data;
  } spg_wr_t;

endpackage

// ===== design/set_partition_generator_core.sv =====
// set partition generator top level: sequencer, output register, config register
// depends on spg_pkg and spg_label_store
//
// Walks through the partitions of a set of set_size elements in lexicographic
// order of restricted growth strings. Write set_size on the config channel
// (cfg_valid_i/cfg_ready_o, cfg_data_i) while the block is idle, then send a
// restart item to load the single-block string; every later item with
// restart_i low advances to the next partition.
// Each item produces n = set_size (clamped to 1 .. 16) results, one per
// element, in order of position, with last_of_run_o on the final one. When
// no next string exists a single result with exhausted_o set is produced and
// the string is kept. An advance scans the labels one per cycle, then a
// write-back pass sweeps all 16 label entries, emitting results on the first
// n of them. A restart skips the scan and goes straight to the sweep; an
// exhausted advance scans and then produces its single result.
// in_ready_o is high only when the sequencer is idle. When the receiver
// stalls, the result held in the output register waits and the sweep stops
// at its next position to emit until the transfer completes. Reset loads the
// all-ones string and sets set_size to 16.
module set_partition_generator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          position_o,
  output logic [4:0]          block_label_o,
  output logic [4:0]          block_count_o,
  output logic                exhausted_o,
  output logic                last_of_run_o
);
  import spg_pkg::*;

  spg_state_e state_q, state_d;
  idx_t       p_q, p_d;
  idx_t       found_q, found_d;
  logic       found_ok_q, found_ok_d;
  logic       clr_q, clr_d;
  lbl_t       runmax_q, runmax_d;
  lbl_t       cnt_q, cnt_d;
  lbl_t       size_q;

  logic       out_valid_q, out_valid_d;
  idx_t       pos_q, pos_d;
  lbl_t       lbl_q, lbl_d;
  lbl_t       ocnt_q, ocnt_d;
  logic       exh_q, exh_d;
  logic       last_q, last_d;
  logic       out_load;

  spg_wr_t    wr;
  lbl_t       rd_data;
  lbl_t       n_eff;
  idx_t       nm1;
  logic       slot_free;
  logic       in_range;
  lbl_t       lbl_inc;
  lbl_t       new_lbl;

  spg_label_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_addr_i(p_q),
    .rd_data_o(rd_data)
  );

  // effective set size, clamped to 1 .. MaxSetSize
  always_comb begin
    if (size_q == LblZero) begin
      n_eff = LblOne;
    end else if (size_q > MaxSize) begin
      n_eff = MaxSize;
    end else begin
      n_eff = size_q;
    end
  end
  assign nm1 = idx_t'(n_eff - LblOne);

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_range  = ({1'b0, p_q} < n_eff);
  assign lbl_inc   = rd_data + LblOne;

  // label written back during the sweep
  always_comb begin
    if (clr_q) begin
      new_lbl = LblOne;
    end else if (p_q < found_q) begin
      new_lbl = rd_data;
    end else if (p_q == found_q) begin
      new_lbl = lbl_inc;
    end else begin
      new_lbl = LblOne;
    end
  end

  // sequencer next state and outputs
  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    found_d    = found_q;
    found_ok_d = found_ok_q;
    clr_d      = clr_q;
    runmax_d   = runmax_q;
    cnt_d      = cnt_q;
    wr         = '{en: 1'b0, addr: p_q, data: new_lbl};
    out_load   = 1'b0;
    pos_d      = pos_q;
    lbl_d      = lbl_q;
    ocnt_d     = ocnt_q;
    exh_d      = exh_q;
    last_d     = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p_d = '0;
          if (restart_i) begin
            clr_d   = 1'b1;
            cnt_d   = LblOne;
            state_d = ST_EMIT;
          end else begin
            clr_d      = 1'b0;
            found_ok_d = 1'b0;
            runmax_d   = LblZero;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rightmost position whose label does not exceed the prefix max
        if ((p_q != '0) && (rd_data <= runmax_q)) begin
          found_d    = p_q;
          found_ok_d = 1'b1;
          cnt_d      = (lbl_inc > runmax_q) ? lbl_inc : runmax_q;
        end
        runmax_d = (rd_data > runmax_q) ? rd_data : runmax_q;
        if (p_q == nm1) begin
          p_d     = '0;
          state_d = found_ok_d ? ST_EMIT : ST_EXH;
        end else begin
          p_d = p_q + idx_t'(1);
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          out_load = 1'b1;
          pos_d    = '0;
          lbl_d    = LblZero;
          ocnt_d   = LblZero;
          exh_d    = 1'b1;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // write back every entry, emit the first n
        if (!in_range || slot_free) begin
          wr.en = 1'b1;
          if (in_range) begin
            out_load = 1'b1;
            pos_d    = p_q;
            lbl_d    = new_lbl;
            ocnt_d   = cnt_q;
            exh_d    = 1'b0;
            last_d   = (p_q == nm1);
          end
          if (p_q == LastIdx) begin
            state_d = ST_IDLE;
          end else begin
            p_d = p_q + idx_t'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      found_ok_q  <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      size_q      <= MaxSize;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      found_ok_q  <= found_ok_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // scan results and output payload
  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    runmax_q <= runmax_d;
    cnt_q    <= cnt_d;
    pos_q    <= pos_d;
    lbl_q    <= lbl_d;
    ocnt_q   <= ocnt_d;
    exh_q    <= exh_d;
    last_q   <= last_d;
  end

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign position_o    = pos_q;
  assign block_label_o = lbl_q;
  assign block_count_o = ocnt_q;
  assign exhausted_o   = exh_q;
  assign last_of_run_o = last_q;

endmodule

// ===== design/spg_label_store.sv =====
// label store: one restricted growth string of MaxSetSize labels
// one write port, one read port; depends on spg_pkg
module spg_label_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spg_pkg::spg_wr_t wr_i,
  input  spg_pkg::idx_t  rd_addr_i,
  output spg_pkg::lbl_t  rd_data_o
);
  import spg_pkg::*;

  lbl_t mem_q [MaxSetSize];

  // labels reset to the single-block string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSetSize; i++) begin
        mem_q[i] <= LblOne;
      end
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule
